// ===== rtl/core/mean_squared_displacement_top_assert.svh =====
// assertion macros for the msd core, clocked on clk with reset rst_n
`ifndef MEAN_SQUARED_DISPLACEMENT_TOP_ASSERT_SVH
`define MEAN_SQUARED_DISPLACEMENT_TOP_ASSERT_SVH

// same-cycle implication
`define MSD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MSD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/msd_pkg.sv =====
// ----------------------------------------------------------------------------
// msd_pkg
// Types and constants shared by the mean squared displacement core.
// ----------------------------------------------------------------------------
`default_nettype none

package msd_pkg;

    localparam int POS_BITS          = 24;
    localparam int IDX_BITS          = 10;
    localparam int AXES              = 3;
    localparam int MAX_PARTICLES_DEF = 1024;
    localparam int DISP_BITS_DEF     = 32;

    typedef logic [1:0] cfg_index_t;

    localparam cfg_index_t CFG_BOX_X          = 2'd0;
    localparam cfg_index_t CFG_BOX_Y          = 2'd1;
    localparam cfg_index_t CFG_BOX_Z          = 2'd2;
    localparam cfg_index_t CFG_PARTICLE_COUNT = 2'd3;

    typedef struct packed {
        logic [IDX_BITS-1:0] particle_index;
        logic [POS_BITS-1:0] pos_x;
        logic [POS_BITS-1:0] pos_y;
        logic [POS_BITS-1:0] pos_z;
        logic                last_in_frame;
    } msd_in_t;

    typedef struct packed {
        logic [31:0] frame_number;
        logic [63:0] msd_value;
    } msd_out_t;

    typedef struct packed {
        logic go;
        logic primed;
        logic clear;
        logic sum_clr;
    } lane_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/msd_lane.sv =====
// ----------------------------------------------------------------------------
// msd_lane
// One axis: position and displacement memories, unwrap step and square sum.
// ----------------------------------------------------------------------------
`default_nettype none

module msd_lane #(
    parameter int MAX_PARTICLES = msd_pkg::MAX_PARTICLES_DEF,
    parameter int DISP_BITS     = msd_pkg::DISP_BITS_DEF,
    parameter int IDX_W         = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  msd_pkg::lane_ctrl_t        ctrl,
    input  logic [IDX_W-1:0]           addr,
    input  logic [msd_pkg::POS_BITS-1:0] pos,
    output logic [63:0]                sum
);
    import msd_pkg::*;

    localparam int WW = ((DISP_BITS > POS_BITS) ? DISP_BITS : POS_BITS) + 1;
    localparam logic signed [WW-1:0] D_MAX =
        {{(WW-DISP_BITS+1){1'b0}}, {(DISP_BITS-1){1'b1}}};
    localparam logic signed [WW-1:0] D_MIN =
        {{(WW-DISP_BITS+1){1'b1}}, {(DISP_BITS-1){1'b0}}};

    logic [POS_BITS-1:0]  prev_mem [MAX_PARTICLES];
    logic [DISP_BITS-1:0] disp_mem [MAX_PARTICLES];

    logic [POS_BITS-1:0]  prev_rd_reg;
    logic [DISP_BITS-1:0] disp_rd_reg;
    logic [POS_BITS-1:0]  pos_reg;
    logic [IDX_W-1:0]     addr_reg;
    logic                 s1_act_reg;
    logic                 s1_prim_reg;
    logic [DISP_BITS-1:0] nd_reg;
    logic                 s2_reg;
    logic [63:0]          sq_reg;
    logic                 s3_reg;
    logic [63:0]          sum_reg;

    logic signed [POS_BITS-1:0]  step;
    logic signed [DISP_BITS-1:0] disp_s;
    logic signed [WW-1:0]        nd_wide;
    logic [DISP_BITS-1:0]        nd;
    logic [DISP_BITS-1:0]        mag;
    logic [63:0]                 mag_w;
    logic [31:0]                 mag_lo;
    logic [63:0]                 sq;
    logic [64:0]                 sum_add;

    // wrapped difference read as two's complement: half box counts as minus half
    always_comb
    begin
        step    = $signed(pos_reg - prev_rd_reg);
        disp_s  = $signed(disp_rd_reg);
        nd_wide = WW'(disp_s) + WW'(step);
        if (nd_wide > D_MAX)
            nd = DISP_BITS'(D_MAX);
        else if (nd_wide < D_MIN)
            nd = DISP_BITS'(D_MIN);
        else
            nd = DISP_BITS'(nd_wide);
    end

    always_comb
    begin
        mag    = nd_reg[DISP_BITS-1] ? (~nd_reg + 1'b1) : nd_reg;
        mag_w  = 64'(mag);
        mag_lo = mag_w[31:0];
        if (|mag_w[63:32])
            sq = '1;
        else
            sq = mag_lo * mag_lo;
        sum_add = 65'(sum_reg) + 65'(sq_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.go)
        begin
            prev_rd_reg <= prev_mem[addr];
        end
        if (s1_act_reg)
        begin
            prev_mem[addr_reg] <= pos_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.go)
        begin
            disp_rd_reg <= disp_mem[addr];
        end
        if (ctrl.clear)
        begin
            disp_mem[addr] <= '0;
        end
        else if (s1_act_reg && s1_prim_reg)
        begin
            disp_mem[addr_reg] <= nd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.go)
        begin
            pos_reg  <= pos;
            addr_reg <= addr;
        end
        nd_reg <= nd;
        sq_reg <= sq;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_act_reg  <= 1'b0;
            s1_prim_reg <= 1'b0;
            s2_reg      <= 1'b0;
            s3_reg      <= 1'b0;
            sum_reg     <= '0;
        end
        else
        begin
            s1_act_reg  <= ctrl.go;
            s1_prim_reg <= ctrl.primed;
            s2_reg      <= s1_act_reg && s1_prim_reg;
            s3_reg      <= s2_reg;
            if (ctrl.sum_clr)
                sum_reg <= '0;
            else if (s3_reg)
                sum_reg <= sum_add[64] ? '1 : sum_add[63:0];
        end
    end

    assign sum = sum_reg;

endmodule

`default_nettype wire

// ===== rtl/core/msd_merge.sv =====
// ----------------------------------------------------------------------------
// msd_merge
// Frame end: weights the axis sums by box side squared, adds, divides.
// ----------------------------------------------------------------------------
`default_nettype none

module msd_merge (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [63:0]       sum_x,
    input  logic [63:0]       sum_y,
    input  logic [63:0]       sum_z,
    input  logic [31:0]       box_x,
    input  logic [31:0]       box_y,
    input  logic [31:0]       box_z,
    input  logic [10:0]       pcount,
    output logic              idle,
    output logic              out_valid,
    input  logic              out_stall,
    output msd_pkg::msd_out_t out_data
);
    import msd_pkg::*;

    typedef enum logic [2:0] {
        M_IDLE, M_BSQ, M_PP, M_ACC, M_SHIFT, M_DIV, M_OUT
    } mstate_t;

    mstate_t     state_reg;
    logic [63:0] sum_reg [AXES];
    logic [1:0]  axis_reg;
    logic [1:0]  part_reg;
    logic [63:0] bsq_reg;
    logic [63:0] pp_reg;
    logic [127:0] acc_reg;
    logic [63:0] total_reg;
    logic [63:0] quo_reg;
    logic [10:0] rem_reg;
    logic [5:0]  bit_reg;
    logic [31:0] frame_reg;
    logic        out_valid_reg;
    msd_out_t    out_data_reg;

    logic [31:0]  box_sel;
    logic [63:0]  sum_sel;
    logic [31:0]  mul_a;
    logic [31:0]  mul_b;
    logic [127:0] pp_shift;
    logic [63:0]  term;
    logic [64:0]  total_add;
    logic [10:0]  divisor;
    logic [11:0]  rem_try;

    always_comb
    begin
        case (axis_reg)
            2'd0:    box_sel = box_x;
            2'd1:    box_sel = box_y;
            default: box_sel = box_z;
        endcase
        case (axis_reg)
            2'd0:    sum_sel = sum_reg[0];
            2'd1:    sum_sel = sum_reg[1];
            default: sum_sel = sum_reg[2];
        endcase
        mul_a = part_reg[1] ? sum_sel[63:32] : sum_sel[31:0];
        mul_b = part_reg[0] ? bsq_reg[63:32] : bsq_reg[31:0];
        // partial product weight follows which halves were taken
        if (part_reg[1] && part_reg[0])
            pp_shift = 128'(pp_reg) << 64;
        else if (part_reg[1] || part_reg[0])
            pp_shift = 128'(pp_reg) << 32;
        else
            pp_shift = 128'(pp_reg);
        // drop the 2^-48 position scale, saturating
        term      = (|acc_reg[127:112]) ? '1 : acc_reg[111:48];
        total_add = 65'(total_reg) + 65'(term);
        divisor   = (pcount == 11'd0) ? 11'd1 : pcount;
        rem_try   = {rem_reg, quo_reg[63]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= M_IDLE;
            axis_reg      <= '0;
            part_reg      <= '0;
            bit_reg       <= '0;
            frame_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                M_IDLE:
                begin
                    if (start)
                    begin
                        sum_reg[0] <= sum_x;
                        sum_reg[1] <= sum_y;
                        sum_reg[2] <= sum_z;
                        axis_reg   <= '0;
                        total_reg  <= '0;
                        frame_reg  <= frame_reg + 32'd1;
                        state_reg  <= M_BSQ;
                    end
                end
                M_BSQ:
                begin
                    bsq_reg   <= box_sel * box_sel;
                    part_reg  <= '0;
                    acc_reg   <= '0;
                    state_reg <= M_PP;
                end
                M_PP:
                begin
                    pp_reg    <= mul_a * mul_b;
                    state_reg <= M_ACC;
                end
                M_ACC:
                begin
                    acc_reg  <= acc_reg + pp_shift;
                    part_reg <= part_reg + 2'd1;
                    if (part_reg == 2'd3)
                        state_reg <= M_SHIFT;
                    else
                        state_reg <= M_PP;
                end
                M_SHIFT:
                begin
                    total_reg <= total_add[64] ? '1 : total_add[63:0];
                    axis_reg  <= axis_reg + 2'd1;
                    if (axis_reg == 2'd2)
                    begin
                        quo_reg   <= total_add[64] ? '1 : total_add[63:0];
                        rem_reg   <= '0;
                        bit_reg   <= '0;
                        state_reg <= M_DIV;
                    end
                    else
                        state_reg <= M_BSQ;
                end
                M_DIV:
                begin
                    // restoring divide, one quotient bit a cycle
                    if (rem_try >= {1'b0, divisor})
                    begin
                        rem_reg <= 11'(rem_try - {1'b0, divisor});
                        quo_reg <= {quo_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_try[10:0];
                        quo_reg <= {quo_reg[62:0], 1'b0};
                    end
                    bit_reg <= bit_reg + 6'd1;
                    if (bit_reg == 6'd63)
                        state_reg <= M_OUT;
                end
                M_OUT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg              <= 1'b1;
                        out_data_reg.frame_number  <= frame_reg;
                        out_data_reg.msd_value     <= quo_reg;
                        state_reg                  <= M_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

    assign idle      = (state_reg == M_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/mean_squared_displacement_top.sv =====
// ----------------------------------------------------------------------------
// mean_squared_displacement_top
// Per-frame mean squared displacement of particles in a periodic box.
//
//   channel | direction | handshake           | payload
//   in      | request   | in_valid / in_stall | in_data (msd_in_t)
//   out     | result    | out_valid/out_stall | out_data (msd_out_t)
//   cfg     | write     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// each request runs through accept with memory read, unwrap and write back,
// square and accumulate, and no new request is taken until it is back in idle,
// as set by the read-modify-write on the per-particle memories.
// after reset a clearing pass over every particle address zeroes the
// displacements with in_stall high; config writes are taken throughout.
// a frame end starts the merge unit: a box square and partial products per
// axis, then a restoring divide, overlapping the next frame's requests.
// a finished result waits in its register while out_stall is high.
// ----------------------------------------------------------------------------
`default_nettype none

module mean_squared_displacement_top #(
    parameter int MAX_PARTICLES = msd_pkg::MAX_PARTICLES_DEF,
    parameter int DISP_BITS     = msd_pkg::DISP_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  msd_pkg::msd_in_t    in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output msd_pkg::msd_out_t   out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  msd_pkg::cfg_index_t cfg_index,
    input  logic [31:0]         cfg_data
);
    import msd_pkg::*;

    localparam int IDX_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_BUSY} state_t;

    state_t           state_reg;
    logic [1:0]       cnt_reg;
    logic             primed_reg;
    logic             last_reg;
    logic [IDX_W-1:0] clr_cnt_reg;
    logic [31:0]      box_x_reg;
    logic [31:0]      box_y_reg;
    logic [31:0]      box_z_reg;
    logic [10:0]      pcount_reg;

    logic                accept;
    logic                in_range;
    logic [IDX_W-1:0]    lane_addr;
    lane_ctrl_t          ctrl;
    logic                merge_start;
    logic                m_idle;
    logic [POS_BITS-1:0] lane_pos [AXES];
    logic [63:0]         lane_sum [AXES];

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign in_range  = (32'(in_data.particle_index) < 32'(MAX_PARTICLES));
    assign lane_addr = (state_reg == S_CLEAR) ? clr_cnt_reg
                                              : IDX_W'(in_data.particle_index);

    assign merge_start = (state_reg == S_BUSY) && (cnt_reg == 2'd3) && last_reg
                         && primed_reg && m_idle;

    always_comb
    begin
        ctrl.go      = accept && in_range;
        ctrl.primed  = primed_reg;
        ctrl.clear   = (state_reg == S_CLEAR);
        ctrl.sum_clr = merge_start;
    end

    assign lane_pos[0] = in_data.pos_x;
    assign lane_pos[1] = in_data.pos_y;
    assign lane_pos[2] = in_data.pos_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_x_reg  <= 32'd65536;
            box_y_reg  <= 32'd65536;
            box_z_reg  <= 32'd65536;
            pcount_reg <= 11'd1024;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_BOX_X:          box_x_reg  <= cfg_data;
                CFG_BOX_Y:          box_y_reg  <= cfg_data;
                CFG_BOX_Z:          box_z_reg  <= cfg_data;
                CFG_PARTICLE_COUNT: pcount_reg <= cfg_data[10:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            cnt_reg     <= '0;
            primed_reg  <= 1'b0;
            last_reg    <= 1'b0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == IDX_W'(MAX_PARTICLES - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        last_reg  <= in_data.last_in_frame;
                        cnt_reg   <= '0;
                        state_reg <= S_BUSY;
                    end
                end
                S_BUSY:
                begin
                    if (cnt_reg != 2'd3)
                        cnt_reg <= cnt_reg + 2'd1;
                    else if (!last_reg)
                        state_reg <= S_IDLE;
                    else if (!primed_reg)
                    begin
                        // priming frame only records positions
                        primed_reg <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                    else if (m_idle)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    for (genvar a = 0; a < AXES; a++)
    begin : g_lane
        msd_lane #(
            .MAX_PARTICLES (MAX_PARTICLES),
            .DISP_BITS     (DISP_BITS),
            .IDX_W         (IDX_W)
        ) u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .addr  (lane_addr),
            .pos   (lane_pos[a]),
            .sum   (lane_sum[a])
        );
    end

    msd_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (merge_start),
        .sum_x     (lane_sum[0]),
        .sum_y     (lane_sum[1]),
        .sum_z     (lane_sum[2]),
        .box_x     (box_x_reg),
        .box_y     (box_y_reg),
        .box_z     (box_z_reg),
        .pcount    (pcount_reg),
        .idle      (m_idle),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

`include "mean_squared_displacement_top_assert.svh"

    `MSD_ASSERT_IMP(a_merge_free, merge_start, m_idle, "merge started while busy")
    `MSD_ASSERT_NXT(a_accept_busy, accept, state_reg == S_BUSY && cnt_reg == 2'd0, "request lost")
    `MSD_ASSERT_IMP(a_no_go_clear, state_reg == S_CLEAR, !ctrl.go, "request during clearing pass")

endmodule

`default_nettype wire
